[rtl/ubpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubpg_pkg
// Shared types and constants of the uart burst pattern generator.
// ----------------------------------------------------------------------------
package ubpg_pkg;

  localparam int unsigned PayloadDepth = 64;
  localparam int unsigned PayloadAw    = $clog2(PayloadDepth);
  localparam int unsigned SlotBits     = 11;
  localparam int unsigned FrameBits    = 8;

  localparam logic [3:0] BitsPerFrame = 4'd10;
  localparam logic [3:0] StopPos      = 4'd9;
  localparam logic [9:0] MinIdle      = 10'd12;
  localparam logic [6:0] MaxFrames    = 7'd64;

  // configuration register indexes
  localparam logic [1:0] CfgFirstByte  = 2'd0;
  localparam logic [1:0] CfgFrameCount = 2'd1;
  localparam logic [1:0] CfgIdleBits   = 2'd2;
  localparam logic [1:0] CfgPayloadLen = 2'd3;

  // input item modes
  localparam logic ModeTick = 1'b0;
  localparam logic ModeLoad = 1'b1;

  typedef enum logic [1:0] {
    SLOT_IDLE,
    SLOT_START,
    SLOT_STOP,
    SLOT_DATA
  } slot_kind_e;

  typedef struct packed {
    slot_kind_e  kind;
    logic [2:0]  bit_sel;
    logic        use_mem;
    logic [7:0]  count_byte;
    logic        burst_end;
  } slot_info_t;

endpackage

[rtl/uart_burst_pattern_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_burst_pattern_generator_unit
// Repeating 8N1 uart burst pattern, one bit time per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): mode_i = 0 is a tick that yields
//   one output transaction with the line level of the next bit slot; mode_i = 1
//   loads payload_byte_i into payload entry payload_index_i, no output.
//   Output channel (out_valid_o / out_stall_i): line_level_o and burst_end_o,
//   the latter high on the last idle slot of each burst.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 first
//   byte, 1 frame count, 2 idle bits, 3 payload length (0 = counting bytes).
//   Write config only while no tick is in flight.
// Timing:
//   A tick passes the synchronous payload memory read, then the output
//   register, before it shows at the output. One transaction per cycle is
//   accepted while the output drains.
//   When out_stall_i holds the output register, the read stage holds too and
//   in_stall_o rises once that stage is occupied.
// Reset:
//   Slot position returns to the start of a burst and the registers take their
//   defaults; payload memory contents are not cleared.
// ----------------------------------------------------------------------------
module uart_burst_pattern_generator_unit
  import ubpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [5:0] payload_index_i,
  input  logic [7:0] payload_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_level_o,
  output logic       burst_end_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  logic [7:0] first_byte_q;
  logic [6:0] frame_count_q;
  logic [9:0] idle_bits_q;
  logic [6:0] payload_length_q;

  logic                 accept;
  logic                 tick;
  logic                 load;
  logic                 hold;
  logic [PayloadAw-1:0] raddr;
  logic [7:0]           rdata;
  slot_info_t           info;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = hold;
  assign accept      = in_valid_i && !hold;
  assign tick        = accept && (mode_i == ModeTick);
  assign load        = accept && (mode_i == ModeLoad)
                    && ({2'b00, payload_index_i} < 8'(PayloadDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_byte_q     <= 8'd65;
      frame_count_q    <= 7'd4;
      idle_bits_q      <= 10'd14;
      payload_length_q <= 7'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgFirstByte:  first_byte_q     <= cfg_data_i[7:0];
        CfgFrameCount: frame_count_q    <= cfg_data_i[6:0];
        CfgIdleBits:   idle_bits_q      <= cfg_data_i;
        CfgPayloadLen: payload_length_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  ubpg_slot_seq u_slot_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_i           (tick),
    .first_byte_i     (first_byte_q),
    .frame_count_i    (frame_count_q),
    .idle_bits_i      (idle_bits_q),
    .payload_length_i (payload_length_q),
    .raddr_o          (raddr),
    .info_o           (info)
  );

  ubpg_payload_ram u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (payload_index_i[PayloadAw-1:0]),
    .wdata_i (payload_byte_i),
    .re_i    (tick),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ubpg_line_out u_line_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .info_i       (info),
    .rdata_i      (rdata),
    .hold_o       (hold),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_level_o (line_level_o),
    .burst_end_o  (burst_end_o)
  );

  // back-pressure only comes from a stalled, full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  // burst end falls on an idle slot, which is high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && burst_end_o) |-> line_level_o)
    else $error("burst end on a low line level");

  // a tick accepted with the output free reaches the output through the read stage and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick && !out_valid_o) |=> ##1 out_valid_o)
    else $error("tick lost in the pipeline");

endmodule

[rtl/ubpg_payload_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubpg_payload_ram
// Payload byte store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ubpg_payload_ram
  import ubpg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [PayloadAw-1:0] waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic                 re_i,
  input  logic [PayloadAw-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem [PayloadDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ubpg_slot_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubpg_slot_seq
// Slot, frame and bit counters of the burst and decode of the current slot.
// ----------------------------------------------------------------------------
module ubpg_slot_seq
  import ubpg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic [7:0]           first_byte_i,
  input  logic [6:0]           frame_count_i,
  input  logic [9:0]           idle_bits_i,
  input  logic [6:0]           payload_length_i,
  output logic [PayloadAw-1:0] raddr_o,
  output slot_info_t           info_o
);

  logic [SlotBits-1:0]  slot_q, slot_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic [3:0]           pos_q, pos_d;

  logic [6:0]          eff_len;
  logic [6:0]          frames;
  logic [9:0]          idle;
  logic [SlotBits-1:0] slots;
  logic [SlotBits-1:0] last;

  always_comb begin
    eff_len = (payload_length_i > MaxFrames) ? MaxFrames : payload_length_i;
    if (eff_len != 7'd0) begin
      frames = eff_len;
    end else if (frame_count_i == 7'd0) begin
      frames = 7'd1;
    end else if (frame_count_i > MaxFrames) begin
      frames = MaxFrames;
    end else begin
      frames = frame_count_i;
    end
    idle  = (idle_bits_i < MinIdle) ? MinIdle : idle_bits_i;
    // frames * 10 as two shifted adds
    slots = {1'b0, frames, 3'b000} + {3'b000, frames, 1'b0}
          + {{(SlotBits-10){1'b0}}, idle};
    last  = slots - {{(SlotBits-1){1'b0}}, 1'b1};
  end

  always_comb begin
    info_o.bit_sel    = 3'(pos_q - 4'd1);
    info_o.use_mem    = (eff_len != 7'd0);
    info_o.count_byte = first_byte_i + frame_q[7:0];
    info_o.burst_end  = (slot_q == last);
    if (frame_q >= {{(FrameBits-7){1'b0}}, frames}) begin
      info_o.kind = SLOT_IDLE;
    end else if (pos_q == 4'd0) begin
      info_o.kind = SLOT_START;
    end else if (pos_q == StopPos) begin
      info_o.kind = SLOT_STOP;
    end else begin
      info_o.kind = SLOT_DATA;
    end
  end

  assign raddr_o = frame_q[PayloadAw-1:0];

  always_comb begin
    slot_d  = slot_q;
    frame_d = frame_q;
    pos_d   = pos_q;
    if (tick_i) begin
      // past the end also restarts, the burst may have shrunk
      if (slot_q >= last) begin
        slot_d  = '0;
        frame_d = '0;
        pos_d   = '0;
      end else begin
        slot_d = slot_q + {{(SlotBits-1){1'b0}}, 1'b1};
        if (pos_q == BitsPerFrame - 4'd1) begin
          pos_d   = '0;
          frame_d = frame_q + {{(FrameBits-1){1'b0}}, 1'b1};
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      frame_q <= '0;
      pos_q   <= '0;
    end else begin
      slot_q  <= slot_d;
      frame_q <= frame_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[rtl/ubpg_line_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubpg_line_out
// Read-data stage and output register: picks the line level of each slot.
// ----------------------------------------------------------------------------
module ubpg_line_out
  import ubpg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_i,
  input  slot_info_t info_i,
  input  logic [7:0] rdata_i,
  output logic       hold_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       line_level_o,
  output logic       burst_end_o
);

  logic       s1_valid_q, s1_valid_d;
  slot_info_t s1_info_q;
  logic       out_valid_q, out_valid_d;
  logic       level_q, end_q;
  logic       advance;
  logic       s1_load;
  logic [7:0] byte_sel;
  logic       level;

  assign advance = !out_valid_q || !out_stall_i;
  assign s1_load = !s1_valid_q || advance;
  assign hold_o  = !s1_load;

  always_comb begin
    byte_sel = s1_info_q.use_mem ? rdata_i : s1_info_q.count_byte;
    unique case (s1_info_q.kind)
      SLOT_IDLE:  level = 1'b1;
      SLOT_START: level = 1'b0;
      SLOT_STOP:  level = 1'b1;
      SLOT_DATA:  level = byte_sel[s1_info_q.bit_sel];
      default:    level = 1'b1;
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_load ? tick_i : s1_valid_q;
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && tick_i) begin
      s1_info_q <= info_i;
    end
    if (advance && s1_valid_q) begin
      level_q <= level;
      end_q   <= s1_info_q.burst_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = level_q;
  assign burst_end_o  = end_q;

endmodule

[bench/ubpg_line_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubpg_line_checker
// Watches the tick, output and config channels of the uart burst pattern
// generator, predicts the line level and burst end of every tick and compares
// them in order with the output transactions.
// ----------------------------------------------------------------------------
module ubpg_line_checker
  import ubpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [5:0]  payload_index_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        line_level_i,
  input  logic        burst_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic line_level;
    logic burst_end;
  } line_bit_t;

  logic [7:0]          first_byte_q;
  logic [6:0]          frame_count_q;
  logic [9:0]          idle_bits_q;
  logic [6:0]          payload_len_q;
  logic [SlotBits-1:0] slot_q;
  logic [7:0]          payload_mirror [PayloadDepth];
  line_bit_t           line_expect_q [$];
  int unsigned         mismatches = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string msg);
    // keep the log short when the design is badly off
    if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned payload_frames();
    return (payload_len_q > PayloadDepth) ? PayloadDepth : payload_len_q;
  endfunction

  function automatic int unsigned frames_per_burst();
    int unsigned n;
    n = payload_frames();
    if (n == 0) begin
      n = frame_count_q;
      if (n < 1) n = 1;
      if (n > MaxFrames) n = MaxFrames;
    end
    return n;
  endfunction

  function automatic int unsigned slots_per_burst();
    int unsigned idle;
    idle = (idle_bits_q < MinIdle) ? MinIdle : idle_bits_q;
    return frames_per_burst() * BitsPerFrame + idle;
  endfunction

  function automatic logic level_at_slot(input int unsigned slot);
    int unsigned frame;
    int unsigned pos;
    logic [7:0]  data;
    frame = slot / BitsPerFrame;
    pos   = slot % BitsPerFrame;
    // idle run, and slots left past a burst that the registers shrank
    if (frame >= frames_per_burst()) return 1'b1;
    if (pos == 0) return 1'b0;
    if (pos == StopPos) return 1'b1;
    if (payload_frames() > 0) data = payload_mirror[frame];
    else data = 8'(first_byte_q + frame);
    return data[pos - 1];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    line_bit_t   want;
    int unsigned last;
    if (!rst_ni) begin
      first_byte_q  = 8'd65;
      frame_count_q = 7'd4;
      idle_bits_q   = 10'd14;
      payload_len_q = 7'd0;
      slot_q        = '0;
      line_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (line_expect_q.size() == 0) begin
          report_mismatch("output transaction with no tick waiting");
        end else begin
          want = line_expect_q.pop_front();
          if (line_level_i !== want.line_level)
            report_mismatch($sformatf("line_level got %b expected %b",
                                      line_level_i, want.line_level));
          if (burst_end_i !== want.burst_end)
            report_mismatch($sformatf("burst_end got %b expected %b",
                                      burst_end_i, want.burst_end));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgFirstByte:  first_byte_q  = cfg_data_i[7:0];
          CfgFrameCount: frame_count_q = cfg_data_i[6:0];
          CfgIdleBits:   idle_bits_q   = cfg_data_i;
          CfgPayloadLen: payload_len_q = cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (mode_i == ModeLoad) begin
          payload_mirror[payload_index_i] = payload_byte_i;
        end else begin
          last = slots_per_burst() - 1;
          want.line_level = level_at_slot(slot_q);
          want.burst_end  = (slot_q == last);
          line_expect_q.push_back(want);
          if (slot_q >= last) slot_q = '0;
          else slot_q = slot_q + 1'b1;
        end
      end

      pending_o <= line_expect_q.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks, payload loads and register writes into the uart burst pattern
// generator with random gaps and output stalls; the line checker beside the
// design predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import ubpg_pkg::*;

  localparam int unsigned ItemTarget  = 1350;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 6;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic        mode          = ModeTick;
  logic [5:0]  payload_index = '0;
  logic [7:0]  payload_byte  = '0;
  logic        out_stall     = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic [1:0]  cfg_index     = CfgFirstByte;
  logic [9:0]  cfg_data      = '0;
  logic        in_stall;
  logic        out_valid;
  logic        line_level;
  logic        burst_end;
  logic        cfg_ready;
  int unsigned pending_results;
  int unsigned failures;

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned rx_wait  = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count;
  logic [6:0]  shadow_payload_len = '0;
  bit          payload_written [PayloadDepth];

  uart_burst_pattern_generator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .payload_index_i(payload_index),
    .payload_byte_i (payload_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .line_level_o   (line_level),
    .burst_end_o    (burst_end),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ubpg_line_checker line_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .mode_i         (mode),
    .payload_index_i(payload_index),
    .payload_byte_i (payload_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .line_level_i   (line_level),
    .burst_end_i    (burst_end),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending_results),
    .fail_count_o   (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: after each output transaction hold stall for a random stretch
  always @(posedge clk_i) begin
    int unsigned rx_draw;
    if (out_valid && !out_stall) begin
      rx_draw = rx_quiet ? 0 : $urandom_range(0, 16);
      rx_wait <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic item_mode, input logic [5:0] index,
                           input logic [7:0] data);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    mode          <= item_mode;
    payload_index <= index;
    payload_byte  <= data;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    if (item_mode == ModeLoad) payload_written[index] = 1'b1;
  endtask

  // leaves cfg_valid high so that writes can go back to back
  task automatic write_register(input logic [1:0] index, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // loads leave no result behind, so keep waiting after the last result is checked
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n_writes;
    int unsigned n_items;
    int unsigned eff_len;
    int unsigned sel;
    logic [1:0]  reg_sel;
    logic [9:0]  reg_val;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: extreme payload values, then ticks through part of a burst
    send_item(ModeLoad, 6'd0, 8'h00);
    send_item(ModeLoad, 6'd63, 8'hff);
    repeat (22) send_item(ModeTick, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    wait_drained();

    // shrink to the shortest burst while the slot sits past its end
    write_register(CfgFrameCount, 10'd0);
    write_register(CfgIdleBits, 10'd0);
    write_register(CfgFirstByte, 10'd255);
    cfg_valid <= 1'b0;
    send_item(ModeTick, 6'd0, 8'd0);
    in_valid <= 1'b0;

    while (items_sent < ItemTarget) begin
      wait_drained();
      n_writes = $urandom_range(1, 4);
      repeat (n_writes) begin
        reg_sel = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 5);
        case (reg_sel)
          CfgFirstByte: begin
            case (sel)
              0: reg_val = 10'd0;
              1: reg_val = 10'd255;
              default: reg_val = 10'($urandom_range(0, 1023));
            endcase
          end
          CfgFrameCount: begin
            case (sel)
              0: reg_val = 10'd1;
              1: reg_val = 10'd64;
              2: reg_val = 10'd0;
              3: reg_val = 10'($urandom_range(65, 127));
              4: reg_val = 10'($urandom_range(128, 1023));
              default: reg_val = 10'($urandom_range(1, 8));
            endcase
          end
          CfgIdleBits: begin
            case (sel)
              0: reg_val = 10'd12;
              1: reg_val = 10'd1023;
              2: reg_val = 10'($urandom_range(0, 11));
              default: reg_val = 10'($urandom_range(12, 40));
            endcase
          end
          default: begin
            case (sel)
              0: reg_val = 10'd64;
              1: reg_val = 10'($urandom_range(65, 1023));
              2, 3: reg_val = 10'($urandom_range(1, 8));
              default: reg_val = 10'd0;
            endcase
          end
        endcase
        write_register(reg_sel, reg_val);
        if (reg_sel == CfgPayloadLen) shadow_payload_len = reg_val[6:0];
      end
      cfg_valid <= 1'b0;

      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);

      // every payload entry the burst will read must hold a byte first
      eff_len = (shadow_payload_len > PayloadDepth) ? PayloadDepth : shadow_payload_len;
      for (int k = 0; k < eff_len; k++) begin
        if (!payload_written[k]) send_item(ModeLoad, 6'(k), 8'($urandom_range(0, 255)));
      end

      n_items = $urandom_range(30, 120);
      for (int i = 0; i < n_items; i++) begin
        if (i == n_items / 2 && $urandom_range(0, 2) == 0) begin
          // hold the sender until the output side has caught up
          in_valid <= 1'b0;
          wait_drained();
        end
        if ($urandom_range(0, 7) == 0)
          send_item(ModeLoad, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        else
          send_item(ModeTick, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
